>>> rtl/fws_pkg.sv
`timescale 1ns / 1ps

package fws_pkg;

	localparam int WHEEL_COUNT      = 4;
	localparam int WINDOW_LEN_DEF   = 10;
	localparam int WARMUP_TICKS_DEF = 20;
	localparam int DRIVE_LIMIT_DEF  = 5000;

	localparam int POS_W   = 13;
	localparam int GOAL_W  = 14;
	localparam int DELTA_W = 14;
	localparam int DRIVE_W = 14;
	localparam int GAIN_W  = 16;

	localparam int POS_MODULUS    = 8191;
	localparam int WRAP_THRESHOLD = 3000;
	// prop_gain is applied in tenths
	localparam int GAIN_SCALE     = 10;

	localparam int        CFG_IDX_W      = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 2'd1;

	localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd1500;
	localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd0;

	typedef struct packed {
		logic adv1;
		logic adv2;
		logic adv3;
		logic adv4;
	} fws_pipe_ctl_t;

	// running sum of the window, signed
	function automatic int sum_width(input int window_len);
		return DELTA_W + $clog2(window_len);
	endfunction

	// speed error in 1/window_len counts, signed
	function automatic int err_width(input int window_len);
		return GOAL_W + 1 + $clog2(window_len);
	endfunction

endpackage

>>> rtl/fws_wheel_err.sv
`timescale 1ns / 1ps

module fws_wheel_err #(
	parameter int WINDOW_LEN = fws_pkg::WINDOW_LEN_DEF,
	localparam int ErrW = fws_pkg::err_width(WINDOW_LEN)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fws_pkg::fws_pipe_ctl_t              ctl,
	input  logic        [fws_pkg::POS_W-1:0]    pos,
	input  logic signed [fws_pkg::GOAL_W-1:0]   goal,
	output logic signed [ErrW-1:0]              err_s2,
	output logic signed [ErrW:0]                derr_s2
);

	localparam int DW   = fws_pkg::DELTA_W;
	localparam int SumW = fws_pkg::sum_width(WINDOW_LEN);

	localparam logic signed [DW:0] WrapHi  = (DW + 1)'(fws_pkg::WRAP_THRESHOLD);
	localparam logic signed [DW:0] WrapLo  = (DW + 1)'(-fws_pkg::WRAP_THRESHOLD);
	localparam logic signed [DW:0] Modulus = (DW + 1)'(fws_pkg::POS_MODULUS);
	localparam logic signed [SumW-1:0] DeadHi = SumW'(WINDOW_LEN / 2);
	localparam logic signed [SumW-1:0] DeadLo = SumW'(-(WINDOW_LEN / 2));

	logic        [fws_pkg::POS_W-1:0] last_q;
	logic signed [DW-1:0]             taps_q [WINDOW_LEN];
	logic signed [SumW-1:0]           sum_q;
	logic signed [ErrW-1:0]           prev_err_q;

	logic signed [DW:0]      d_raw;
	logic signed [DW:0]      d_fix;
	logic signed [DW-1:0]    delta;
	logic signed [SumW-1:0]  sum_nx;
	logic signed [SumW-1:0]  speed;
	logic signed [ErrW-1:0]  goal_scaled;
	logic signed [ErrW-1:0]  err_nx;
	logic signed [ErrW:0]    derr_nx;

	always_comb begin
		d_raw = $signed({2'b00, pos}) - $signed({2'b00, last_q});
		// take the short way around the encoder
		if (d_raw > WrapHi) begin
			d_fix = d_raw - Modulus;
		end else if (d_raw < WrapLo) begin
			d_fix = d_raw + Modulus;
		end else begin
			d_fix = d_raw;
		end
		delta = d_fix[DW-1:0];

		sum_nx = sum_q + SumW'(delta) - SumW'(taps_q[WINDOW_LEN-1]);
		// drop speeds of half a count or less
		if (sum_nx >= DeadLo && sum_nx <= DeadHi) begin
			speed = '0;
		end else begin
			speed = sum_nx;
		end

		goal_scaled = ErrW'(goal) * ErrW'(WINDOW_LEN);
		err_nx      = goal_scaled - ErrW'(speed);
		derr_nx     = (ErrW + 1)'(err_nx) - (ErrW + 1)'(prev_err_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q     <= '0;
			sum_q      <= '0;
			prev_err_q <= '0;
			for (int k = 0; k < WINDOW_LEN; k++) begin
				taps_q[k] <= '0;
			end
		end else if (ctl.adv1) begin
			last_q     <= pos;
			sum_q      <= sum_nx;
			prev_err_q <= err_nx;
			taps_q[0]  <= delta;
			for (int k = 1; k < WINDOW_LEN; k++) begin
				taps_q[k] <= taps_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv1) begin
			err_s2  <= err_nx;
			derr_s2 <= derr_nx;
		end
	end

endmodule

>>> rtl/fws_wheel_pd.sv
`timescale 1ns / 1ps

module fws_wheel_pd #(
	parameter int WINDOW_LEN  = fws_pkg::WINDOW_LEN_DEF,
	parameter int DRIVE_LIMIT = fws_pkg::DRIVE_LIMIT_DEF,
	localparam int ErrW = fws_pkg::err_width(WINDOW_LEN)
) (
	input  logic                                 clk,
	input  fws_pkg::fws_pipe_ctl_t               ctl,
	input  logic        [fws_pkg::GAIN_W-1:0]    prop_gain,
	input  logic        [fws_pkg::GAIN_W-1:0]    deriv_gain,
	input  logic signed [ErrW-1:0]               err_s2,
	input  logic signed [ErrW:0]                 derr_s2,
	input  logic                                 en_s4,
	output logic signed [fws_pkg::DRIVE_W-1:0]   drive_q
);

	localparam int GW    = fws_pkg::GAIN_W;
	localparam int PW    = ErrW + GW + 1;
	localparam int DPW   = ErrW + GW + 2;
	localparam int NumW  = ErrW + GW + 7;
	localparam int Div   = fws_pkg::GAIN_SCALE * WINDOW_LEN;
	localparam int NumHiInt = (DRIVE_LIMIT + 1) * Div;
	localparam int MagW  = $clog2(NumHiInt);
	localparam int Shift = MagW + $clog2(Div);
	localparam int ScW   = 2 * MagW + 2;
	localparam int CalcW = 17;

	localparam logic signed [NumW-1:0] NumHi = NumW'(NumHiInt);
	localparam logic signed [NumW-1:0] NumLo = NumW'(-NumHiInt);
	localparam logic [63:0] Recip = ((64'd1 << Shift) + 64'(Div - 1)) / 64'(Div);
	localparam logic signed [CalcW-1:0] LimitP = CalcW'(DRIVE_LIMIT);
	localparam logic signed [CalcW-1:0] LimitN = CalcW'(-DRIVE_LIMIT);

	logic signed [PW-1:0]   prod_p_s3;
	logic signed [DPW-1:0]  prod_d_s3;

	logic signed [NumW-1:0] num;
	logic signed [NumW-1:0] num_abs;

	logic                   sat_hi_s4;
	logic                   sat_lo_s4;
	logic                   neg_s4;
	logic [MagW-1:0]        mag_s4;

	logic [ScW-1:0]         scaled;
	logic [ScW-1:0]         quo_wide;
	logic signed [CalcW-1:0] quo;
	logic signed [CalcW-1:0] drive_nx;

	always_ff @(posedge clk) begin
		if (ctl.adv2) begin
			prod_p_s3 <= $signed({1'b0, prop_gain}) * err_s2;
			prod_d_s3 <= $signed({1'b0, deriv_gain}) * derr_s2;
		end
	end

	always_comb begin
		// num = prop*e + 10*deriv*de
		num = NumW'(prod_p_s3) + (NumW'(prod_d_s3) <<< 3) + (NumW'(prod_d_s3) <<< 1);
		num_abs = num[NumW-1] ? -num : num;
	end

	always_ff @(posedge clk) begin
		if (ctl.adv3) begin
			sat_hi_s4 <= (num >= NumHi);
			sat_lo_s4 <= (num <= NumLo);
			neg_s4    <= num[NumW-1];
			mag_s4    <= num_abs[MagW-1:0];
		end
	end

	always_comb begin
		// exact floor division by reciprocal for magnitudes below the clamp
		scaled   = ScW'(mag_s4) * ScW'(Recip);
		quo_wide = scaled >> Shift;
		quo      = $signed(CalcW'(quo_wide));
		priority if (sat_hi_s4) begin
			drive_nx = LimitP;
		end else if (sat_lo_s4) begin
			drive_nx = LimitN;
		end else if (neg_s4) begin
			drive_nx = -quo;
		end else begin
			drive_nx = quo;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv4) begin
			drive_q <= en_s4 ? drive_nx[fws_pkg::DRIVE_W-1:0] : '0;
		end
	end

endmodule

>>> rtl/four_wheel_speed_pd_loop.sv
`timescale 1ns / 1ps

// Four-wheel speed loop: encoder delta, moving average, deadband, PD drive.
// Input channel (in_valid/in_ready) takes one item per control tick: four
// encoder positions, four target speeds and motors_enabled. Output channel
// (out_valid/out_ready) delivers the four clamped drive words.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
// index 0 is prop_gain, index 1 is deriv_gain, other indexes are dropped.
// Write gains only while no item is in flight.
// A result passes the input register, error stage, multiply stage,
// sum/clamp stage and result register. Throughput: one item per cycle
// while out_ready does not stall the output; the per-wheel filter state
// and previous error close their loop within the single error stage.
// The first WARMUP_TICKS items update the filters but produce no result.
// With motors_enabled low the result carries all-zero drive words.
// Reset clears positions, windows, sums, previous errors, the warmup count
// and all valid flags; gains return to 1500 and 0.
// When out_ready is low the result register holds, the stages behind it
// keep filling, and in_ready drops only once every stage holds an item.

module four_wheel_speed_pd_loop #(
	parameter int WINDOW_LEN   = fws_pkg::WINDOW_LEN_DEF,
	parameter int WARMUP_TICKS = fws_pkg::WARMUP_TICKS_DEF,
	parameter int DRIVE_LIMIT  = fws_pkg::DRIVE_LIMIT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic        [fws_pkg::POS_W-1:0]     pos_wheel0,
	input  logic        [fws_pkg::POS_W-1:0]     pos_wheel1,
	input  logic        [fws_pkg::POS_W-1:0]     pos_wheel2,
	input  logic        [fws_pkg::POS_W-1:0]     pos_wheel3,
	input  logic signed [fws_pkg::GOAL_W-1:0]    goal_wheel0,
	input  logic signed [fws_pkg::GOAL_W-1:0]    goal_wheel1,
	input  logic signed [fws_pkg::GOAL_W-1:0]    goal_wheel2,
	input  logic signed [fws_pkg::GOAL_W-1:0]    goal_wheel3,
	input  logic                                 motors_enabled,

	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [fws_pkg::DRIVE_W-1:0]   drive_wheel0,
	output logic signed [fws_pkg::DRIVE_W-1:0]   drive_wheel1,
	output logic signed [fws_pkg::DRIVE_W-1:0]   drive_wheel2,
	output logic signed [fws_pkg::DRIVE_W-1:0]   drive_wheel3,

	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic        [fws_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [fws_pkg::GAIN_W-1:0]    cfg_data
);

	localparam int NW    = fws_pkg::WHEEL_COUNT;
	localparam int ErrW  = fws_pkg::err_width(WINDOW_LEN);
	localparam int WarmW = (WARMUP_TICKS > 0) ? $clog2(WARMUP_TICKS + 1) : 1;
	localparam logic [WarmW-1:0] WarmDone = WarmW'(WARMUP_TICKS);

	logic [fws_pkg::GAIN_W-1:0] prop_gain_q;
	logic [fws_pkg::GAIN_W-1:0] deriv_gain_q;

	logic [WarmW-1:0] warm_q;
	logic             has_result;

	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic en_s1, en_s2, en_s3, en_s4;
	logic accept;

	logic        [fws_pkg::POS_W-1:0]   pos_in  [NW];
	logic signed [fws_pkg::GOAL_W-1:0]  goal_in [NW];
	logic        [fws_pkg::POS_W-1:0]   pos_s1  [NW];
	logic signed [fws_pkg::GOAL_W-1:0]  goal_s1 [NW];
	logic signed [ErrW-1:0]             err_s2  [NW];
	logic signed [ErrW:0]               derr_s2 [NW];
	logic signed [fws_pkg::DRIVE_W-1:0] drive   [NW];

	fws_pkg::fws_pipe_ctl_t ctl;

	assign pos_in[0]  = pos_wheel0;
	assign pos_in[1]  = pos_wheel1;
	assign pos_in[2]  = pos_wheel2;
	assign pos_in[3]  = pos_wheel3;
	assign goal_in[0] = goal_wheel0;
	assign goal_in[1] = goal_wheel1;
	assign goal_in[2] = goal_wheel2;
	assign goal_in[3] = goal_wheel3;

	assign drive_wheel0 = drive[0];
	assign drive_wheel1 = drive[1];
	assign drive_wheel2 = drive[2];
	assign drive_wheel3 = drive[3];

	// each stage moves when the one ahead is empty or moving too
	always_comb begin
		ctl.adv4 = v_s4 && (!out_valid_q || out_ready);
		ctl.adv3 = v_s3 && (!v_s4 || ctl.adv4);
		ctl.adv2 = v_s2 && (!v_s3 || ctl.adv3);
		ctl.adv1 = v_s1 && (!v_s2 || ctl.adv2);
	end

	assign in_ready   = !v_s1 || ctl.adv1;
	assign accept     = in_valid && in_ready;
	assign out_valid  = out_valid_q;
	assign cfg_ready  = 1'b1;
	assign has_result = (warm_q == WarmDone);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= fws_pkg::PROP_GAIN_RST;
			deriv_gain_q <= fws_pkg::DERIV_GAIN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				fws_pkg::CFG_PROP_GAIN: begin
					prop_gain_q <= cfg_data;
				end
				fws_pkg::CFG_DERIV_GAIN: begin
					deriv_gain_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q      <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.adv1 && !has_result) begin
				warm_q <= warm_q + 1'b1;
			end

			if (accept) begin
				v_s1 <= 1'b1;
			end else if (ctl.adv1) begin
				v_s1 <= 1'b0;
			end

			// warmup items update the filters and stop here
			if (ctl.adv1 && has_result) begin
				v_s2 <= 1'b1;
			end else if (ctl.adv2) begin
				v_s2 <= 1'b0;
			end

			if (ctl.adv2) begin
				v_s3 <= 1'b1;
			end else if (ctl.adv3) begin
				v_s3 <= 1'b0;
			end

			if (ctl.adv3) begin
				v_s4 <= 1'b1;
			end else if (ctl.adv4) begin
				v_s4 <= 1'b0;
			end

			if (ctl.adv4) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1  <= pos_in;
			goal_s1 <= goal_in;
			en_s1   <= motors_enabled;
		end
		if (ctl.adv1) begin
			en_s2 <= en_s1;
		end
		if (ctl.adv2) begin
			en_s3 <= en_s2;
		end
		if (ctl.adv3) begin
			en_s4 <= en_s3;
		end
	end

	for (genvar w = 0; w < NW; w++) begin : g_wheel
		fws_wheel_err #(
			.WINDOW_LEN (WINDOW_LEN)
		) u_err (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.pos     (pos_s1[w]),
			.goal    (goal_s1[w]),
			.err_s2  (err_s2[w]),
			.derr_s2 (derr_s2[w])
		);

		fws_wheel_pd #(
			.WINDOW_LEN  (WINDOW_LEN),
			.DRIVE_LIMIT (DRIVE_LIMIT)
		) u_pd (
			.clk        (clk),
			.ctl        (ctl),
			.prop_gain  (prop_gain_q),
			.deriv_gain (deriv_gain_q),
			.err_s2     (err_s2[w]),
			.derr_s2    (derr_s2[w]),
			.en_s4      (en_s4),
			.drive_q    (drive[w])
		);
	end

	a_warm_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		warm_q <= WarmDone)
		else $error("warmup count ran past its limit");

	a_warmup_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.adv1 && !has_result) |=> !v_s2)
		else $error("warmup item produced a result");

	a_s4_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !ctl.adv4) |=> v_s4)
		else $error("stalled stage 4 item lost");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ready)
		else $error("input stalled with empty input register");

endmodule

>>> tb/sv/four_wheel_speed_pd_loop_tb.sv
`timescale 1ns / 1ps

module four_wheel_speed_pd_loop_tb;
	import fws_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
	localparam int SETTLE_CYCLES = 12;

	typedef struct packed {
		logic [WHEEL_COUNT-1:0][POS_W-1:0]  pos;
		logic [WHEEL_COUNT-1:0][GOAL_W-1:0] goal;
		logic                               enable;
	} tick_t;

	typedef logic [WHEEL_COUNT-1:0][DRIVE_W-1:0] drive_set_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_ready;
	logic [POS_W-1:0] pos_wheel0 = '0, pos_wheel1 = '0, pos_wheel2 = '0, pos_wheel3 = '0;
	logic signed [GOAL_W-1:0] goal_wheel0 = '0, goal_wheel1 = '0;
	logic signed [GOAL_W-1:0] goal_wheel2 = '0, goal_wheel3 = '0;
	logic motors_enabled = 1'b0;

	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [DRIVE_W-1:0] drive_wheel0, drive_wheel1, drive_wheel2, drive_wheel3;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_PROP_GAIN;
	logic [GAIN_W-1:0] cfg_data = '0;

	four_wheel_speed_pd_loop u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.pos_wheel0     (pos_wheel0),
		.pos_wheel1     (pos_wheel1),
		.pos_wheel2     (pos_wheel2),
		.pos_wheel3     (pos_wheel3),
		.goal_wheel0    (goal_wheel0),
		.goal_wheel1    (goal_wheel1),
		.goal_wheel2    (goal_wheel2),
		.goal_wheel3    (goal_wheel3),
		.motors_enabled (motors_enabled),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.drive_wheel0   (drive_wheel0),
		.drive_wheel1   (drive_wheel1),
		.drive_wheel2   (drive_wheel2),
		.drive_wheel3   (drive_wheel3),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// speed loop predictor state
	logic [GAIN_W-1:0] prop_gain_q  = PROP_GAIN_RST;
	logic [GAIN_W-1:0] deriv_gain_q = DERIV_GAIN_RST;
	int     last_pos   [WHEEL_COUNT];
	int     delta_hist [WHEEL_COUNT][WINDOW_LEN_DEF];
	longint win_sum    [WHEEL_COUNT];
	longint prev_err   [WHEEL_COUNT];
	int     win_slot   = 0;
	int     warm_ticks = 0;

	drive_set_t pending_drives[$];
	int fault_count = 0;
	int burst_left  = 0;

	// motion generator state
	int wheel_pos  [WHEEL_COUNT];
	int wheel_rate [WHEEL_COUNT];

	logic [8:0] stall_phase = '0;

	initial begin
		for (int w = 0; w < WHEEL_COUNT; w++) begin
			last_pos[w]   = 0;
			win_sum[w]    = 0;
			prev_err[w]   = 0;
			wheel_pos[w]  = 0;
			wheel_rate[w] = 0;
			for (int k = 0; k < WINDOW_LEN_DEF; k++)
				delta_hist[w][k] = 0;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		fault_count++;
	endtask

	task automatic advance_loop(input tick_t t);
		drive_set_t r;
		int d;
		longint s, s_mag, goal, e, num, drv;
		for (int w = 0; w < WHEEL_COUNT; w++) begin
			d = int'(t.pos[w]) - last_pos[w];
			if (d > WRAP_THRESHOLD || d < -WRAP_THRESHOLD)
				d = (d < 0) ? d + POS_MODULUS : d - POS_MODULUS;
			last_pos[w] = int'(t.pos[w]);
			win_sum[w] += longint'(d) - longint'(delta_hist[w][win_slot]);
			delta_hist[w][win_slot] = d;

			s = win_sum[w];
			s_mag = (s < 0) ? -s : s;
			if (2 * s_mag <= WINDOW_LEN_DEF)
				s = 0;

			goal = longint'($signed(t.goal[w]));
			e = goal * WINDOW_LEN_DEF - s;
			num = longint'(prop_gain_q) * e
				+ 10 * longint'(deriv_gain_q) * (e - prev_err[w]);
			prev_err[w] = e;

			drv = num / (GAIN_SCALE * WINDOW_LEN_DEF);
			if (drv > DRIVE_LIMIT_DEF)
				drv = DRIVE_LIMIT_DEF;
			else if (drv < -DRIVE_LIMIT_DEF)
				drv = -DRIVE_LIMIT_DEF;
			r[w] = t.enable ? drv[DRIVE_W-1:0] : '0;
		end

		win_slot = (win_slot + 1 >= WINDOW_LEN_DEF) ? 0 : win_slot + 1;

		if (warm_ticks < WARMUP_TICKS_DEF)
			warm_ticks++;
		else
			pending_drives.push_back(r);
	endtask

	function automatic tick_t make_tick(input int p0, p1, p2, p3, g0, g1, g2, g3,
	                                    input bit en);
		tick_t t;
		t.pos     = {p3[POS_W-1:0], p2[POS_W-1:0], p1[POS_W-1:0], p0[POS_W-1:0]};
		t.goal    = {g3[GOAL_W-1:0], g2[GOAL_W-1:0], g1[GOAL_W-1:0], g0[GOAL_W-1:0]};
		t.enable  = en;
		return t;
	endfunction

	// Mostly wheels turning at a steady speed with goals near it; the rest is noise.
	function automatic tick_t next_motion_tick();
		tick_t t;
		int kind, g;
		kind = $urandom_range(0, 99);
		for (int w = 0; w < WHEEL_COUNT; w++) begin
			if ($urandom_range(0, 15) == 0)
				wheel_rate[w] = int'($urandom_range(0, 800)) - 400;
			if (kind < 5)
				wheel_rate[w] = int'($urandom_range(0, 6000)) - 3000;
			wheel_pos[w] = (wheel_pos[w] + wheel_rate[w] + int'($urandom_range(0, 4)) - 2)
				& 32'h1FFF;
			if (kind < 70) begin
				g = wheel_rate[w] + int'($urandom_range(0, 60)) - 30;
				if ($urandom_range(0, 19) == 0)
					g = int'($urandom_range(0, 2000)) - 1000;
				t.pos[w] = wheel_pos[w][POS_W-1:0];
			end else if (kind < 85) begin
				g = int'($urandom_range(0, 16383));
				t.pos[w] = POS_W'($urandom_range(0, 8191));
			end else begin
				g = int'($urandom_range(0, 16383));
				t.pos[w] = wheel_pos[w][POS_W-1:0];
			end
			t.goal[w] = g[GOAL_W-1:0];
		end
		t.enable = (kind < 70) ? ($urandom_range(0, 9) != 0) : 1'($urandom_range(0, 1));
		return t;
	endfunction

	task automatic send_tick(input tick_t t);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : $urandom_range(1, 4);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		burst_left--;
		pos_wheel0     = t.pos[0];
		pos_wheel1     = t.pos[1];
		pos_wheel2     = t.pos[2];
		pos_wheel3     = t.pos[3];
		goal_wheel0    = t.goal[0];
		goal_wheel1    = t.goal[1];
		goal_wheel2    = t.goal[2];
		goal_wheel3    = t.goal[3];
		motors_enabled = t.enable;
		in_valid       = 1'b1;
		do @(posedge clk); while (!in_ready);
		advance_loop(t);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid   = 1'b0;
		burst_left = 0;
		while (pending_drives.size() != 0)
			@(posedge clk);
		// warmup items give no result; let the pipeline empty anyway
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_PROP_GAIN:  prop_gain_q  = val;
			CFG_DERIV_GAIN: deriv_gain_q = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	always @(negedge clk) begin
		stall_phase <= stall_phase + 1'b1;
		case (stall_phase[8:7])
			2'd0: out_ready <= 1'b1;
			2'd1: out_ready <= 1'($urandom_range(0, 1));
			2'd2: out_ready <= (stall_phase[2:0] == 3'd0);
			default: out_ready <= (stall_phase[5:3] != 3'd0);
		endcase
	end

	drive_set_t got_drives, want_drives;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_drives = {drive_wheel3, drive_wheel2, drive_wheel1, drive_wheel0};
			if (pending_drives.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", got_drives));
			end else begin
				want_drives = pending_drives.pop_front();
				for (int w = 0; w < WHEEL_COUNT; w++)
					if (got_drives[w] !== want_drives[w])
						report_mismatch($sformatf("drive_wheel%0d got %0d want %0d", w,
							$signed(got_drives[w]), $signed(want_drives[w])));
			end
		end
	end

	// Reset gains stay in force; the first WARMUP_TICKS items give nothing.
	task automatic test_warmup();
		// first item measures from zero: full-scale position wraps back to zero
		send_tick(make_tick(8191, 8191, 8191, 8191, 8191, -8192, 0, -1, 1'b1));
		send_tick(make_tick(0, 0, 0, 0, -8191, 8191, 1, 0, 1'b0));
		repeat (WARMUP_TICKS_DEF - 2) send_tick(next_motion_tick());
		drain_results();
	endtask

	task automatic test_directed_edges();
		int extremes [6] = '{8191, -8191, -8192, 0, 1, -1};
		// hold still long enough to flush the window, goals at their extremes
		for (int i = 0; i < WINDOW_LEN_DEF + 1; i++)
			send_tick(make_tick(100, 1000, 1000, 5000, extremes[i % 6], extremes[(i + 1) % 6],
				extremes[(i + 2) % 6], extremes[(i + 3) % 6], i != 4));
		// deadband edge on wheel 0, wrap threshold on the others
		send_tick(make_tick(105, 4000, 4001, 1999, 0, 0, 0, 0, 1'b1));
		send_tick(make_tick(106, 1000, 8191, 0, 1, -1, 3, -3, 1'b1));
		send_tick(make_tick(106, 1000, 0, 8191, 0, 0, 0, 0, 1'b1));
		// clamps in both directions, masked then driven
		send_tick(make_tick(106, 1000, 0, 8191, 8191, -8192, 8191, -8192, 1'b0));
		send_tick(make_tick(106, 1000, 0, 8191, 8191, -8192, 8191, -8192, 1'b1));
		drain_results();
	endtask

	task automatic test_gain_extremes();
		logic [GAIN_W-1:0] prop_set  [5] = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd1};
		logic [GAIN_W-1:0] deriv_set [5] = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1};
		for (int i = 0; i < 5; i++) begin
			write_reg(CFG_PROP_GAIN, prop_set[i]);
			write_reg(CFG_DERIV_GAIN, deriv_set[i]);
			if (i == 4) begin
				// spare indexes must not touch either gain
				write_reg(CFG_SPARE_2, 16'hFFFF);
				write_reg(CFG_SPARE_3, GAIN_W'($urandom_range(0, 65535)));
			end
			repeat (40) send_tick(next_motion_tick());
			drain_results();
		end
	endtask

	task automatic test_random_motion();
		logic [GAIN_W-1:0] pg, dg;
		for (int phase = 0; phase < 6; phase++) begin
			pg = ($urandom_range(0, 3) == 0) ? GAIN_W'($urandom_range(0, 65535))
				: GAIN_W'($urandom_range(0, 400));
			dg = ($urandom_range(0, 3) == 0) ? GAIN_W'($urandom_range(0, 65535))
				: GAIN_W'($urandom_range(0, 50));
			write_reg(CFG_PROP_GAIN, pg);
			write_reg(CFG_DERIV_GAIN, dg);
			repeat (200) send_tick(next_motion_tick());
			drain_results();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_warmup();
		test_directed_edges();
		test_gain_extremes();
		test_random_motion();

		if (fault_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("ERROR: run timed out with %0d results pending", pending_drives.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
